// File: hdl/hdc_pkg.sv
// shared types and constants of the heater duty controller
package hdc_pkg;

  localparam int RAW_W      = 12;
  localparam int DEG_W      = 8;
  localparam int TARGET_W   = 8;
  localparam int FS_W       = 10;
  localparam int LEVEL_W    = 11;
  localparam int ACC_W      = 12;
  localparam int ERR_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [ACC_W-1:0]           ACC_TOP        = '1;
  localparam logic signed [TARGET_W-1:0] TARGET_HIGH_RST = 8'sd70;
  localparam logic signed [TARGET_W-1:0] TARGET_LOW_RST  = 8'sd0;
  localparam logic [FS_W-1:0]            FULL_SCALE_RST = 10'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_HIGH = 2'd0,
    CFG_TARGET_LOW  = 2'd1,
    CFG_FULL_SCALE  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [TARGET_W-1:0] target_high;
    logic signed [TARGET_W-1:0] target_low;
    logic [FS_W-1:0]            full_scale;
  } cfg_t;

endpackage

// File: hdl/hdc_cfg_regs.sv
// configuration register file of the heater duty controller
module hdc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [hdc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [hdc_pkg::CFG_DATA_W-1:0] wr_data,
  output hdc_pkg::cfg_t                  cfg
);
  import hdc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_high <= TARGET_HIGH_RST;
      cfg_r.target_low  <= TARGET_LOW_RST;
      cfg_r.full_scale  <= FULL_SCALE_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TARGET_HIGH: cfg_r.target_high <= $signed(wr_data[TARGET_W-1:0]);
        CFG_TARGET_LOW:  cfg_r.target_low  <= $signed(wr_data[TARGET_W-1:0]);
        CFG_FULL_SCALE:  cfg_r.full_scale  <= wr_data[FS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/hdc_duty_core.sv
// per-tick duty accumulator and pd level update with its state registers
module hdc_duty_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step_en,
  input  logic signed [hdc_pkg::RAW_W-1:0]  raw_reading,
  input  logic                              select_high,
  input  hdc_pkg::cfg_t                     cfg,
  output logic                              heater_on,
  output logic [hdc_pkg::LEVEL_W-1:0]       drive_level,
  output logic signed [hdc_pkg::DEG_W-1:0]  measured_degrees
);
  import hdc_pkg::*;

  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic [LEVEL_W-1:0]        level_r, level_nxt;
  logic signed [ERR_W-1:0]   e1_r, e1_nxt;

  logic signed [RAW_W-1:0]    raw_adj;
  logic signed [DEG_W-1:0]    degrees;
  logic signed [TARGET_W-1:0] target;
  logic signed [ERR_W-1:0]    err;
  logic [ACC_W:0]             sum;
  logic [ACC_W-1:0]           sum_sat;
  logic signed [ERR_W:0]      e_sum, e_half, e_diff;
  logic signed [ACC_W-1:0]    tot, step;
  logic signed [ACC_W:0]      nl;
  logic signed [ACC_W:0]      fs_plus1;

  always_comb begin
    // whole degrees, truncated toward zero
    raw_adj = raw_reading + (raw_reading[RAW_W-1] ? 12'sd15 : 12'sd0);
    degrees = raw_adj[RAW_W-1:4];
    target  = select_high ? cfg.target_high : cfg.target_low;
    err     = $signed({target[TARGET_W-1], target}) - $signed({degrees[DEG_W-1], degrees});

    // duty accumulator, saturating before the modulus compare
    sum     = {1'b0, acc_r} + {2'b00, level_r};
    sum_sat = sum[ACC_W] ? ACC_TOP : sum[ACC_W-1:0];
    heater_on = sum_sat > {2'b00, cfg.full_scale};
    acc_nxt = heater_on ? sum_sat - {2'b00, cfg.full_scale} : sum_sat;

    // pd step, each halving truncated toward zero
    e_sum  = $signed({e1_r[ERR_W-1], e1_r}) + $signed({err[ERR_W-1], err});
    e_half = (e_sum + (e_sum[ERR_W] ? 10'sd1 : 10'sd0)) >>> 1;
    e_diff = $signed({err[ERR_W-1], err}) - $signed({e1_r[ERR_W-1], e1_r});
    tot    = $signed({{3{err[ERR_W-1]}}, err}) + $signed({{2{e_half[ERR_W]}}, e_half})
           + $signed({{2{e_diff[ERR_W]}}, e_diff});
    step   = (tot + (tot[ACC_W-1] ? 12'sd1 : 12'sd0)) >>> 1;
    nl     = $signed({2'b00, level_r}) + $signed({step[ACC_W-1], step});
    fs_plus1 = $signed({3'b000, cfg.full_scale} + 13'd1);

    level_nxt = level_r;
    e1_nxt    = e1_r;
    if (degrees != target) begin
      if (e1_r == '0) begin
        e1_nxt = err;
      end else begin
        e1_nxt = '0;
        if (nl < 0) begin
          level_nxt = '0;
        end else if (nl > fs_plus1) begin
          level_nxt = {1'b0, cfg.full_scale};
        end else begin
          level_nxt = nl[LEVEL_W-1:0];
        end
      end
    end

    drive_level      = level_nxt;
    measured_degrees = degrees;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      level_r <= '0;
      e1_r    <= '0;
    end else if (step_en) begin
      acc_r   <= acc_nxt;
      level_r <= level_nxt;
      e1_r    <= e1_nxt;
    end
  end

endmodule

// File: hdl/heater_duty_controller_top.sv
// top level of the heater duty controller: channels, input and result registers
//
// one control tick enters on the in_ stream: in_tdata carries the signed
// reading in sixteenths of a degree, in_tuser the setpoint select. for every
// tick exactly one result leaves on the out_ stream with the heater bit,
// the updated drive level and the reading in whole degrees.
// a tick is registered in the input register on its input transfer, then
// worked through the accumulator and pd update; its result is registered in
// the output register when the tick advances and sits there until taken, and
// out_tvalid is driven straight from that register.
// one tick per cycle is sustained while out_tready stays high; the only loop
// is the accumulator/level/first-error state, which closes through its own registers.
// when the receiver stalls, the result holds in the output register and the
// input register still takes one more tick; after that in_tready drops
// until out_tready returns, so nothing is lost or repeated.
// the cfg_ channel writes target_high (0), target_low (1) and full_scale (2);
// other indexes are ignored, cfg_ready is always high, writes are meant to
// land while the block is idle.
// reset (rst_n low, synchronous) empties both registers, clears the
// accumulator, level and captured error and loads the register defaults.
module heater_duty_controller_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hdc_pkg::IN_DATA_W-1:0]     in_tdata,   // [11:0] raw_reading, [15:12] zero
  input  logic                              in_tuser,   // [0] select_high
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hdc_pkg::OUT_DATA_W-1:0]    out_tdata,  // [0] heater_on, [11:1] drive_level,
                                                        // [19:12] measured_degrees, [23:20] zero
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hdc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hdc_pkg::*;

  cfg_t cfg;

  // input register
  logic                    s1_valid_r;
  logic signed [RAW_W-1:0] s1_raw_r;
  logic                    s1_sel_r;

  // result register
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;

  logic                    advance;
  logic                    heater_on;
  logic [LEVEL_W-1:0]      drive_level;
  logic signed [DEG_W-1:0] measured_degrees;

  // a tick moves on when the result register is empty or being drained
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  hdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  hdc_duty_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (advance),
    .raw_reading      (s1_raw_r),
    .select_high      (s1_sel_r),
    .cfg              (cfg),
    .heater_on        (heater_on),
    .drive_level      (drive_level),
    .measured_degrees (measured_degrees)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_raw_r <= $signed(in_tdata[RAW_W-1:0]);
      s1_sel_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {4'b0000, measured_degrees, drive_level, heater_on};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
